### sv/apsp_pkg.sv
package apsp_pkg;

	// Width of one distance entry and the marker for a missing edge.
	localparam int DIST_W = 14;
	localparam logic [DIST_W-1:0] NO_EDGE = 14'd9999;

	// Width of the vertex count register and its reset value.
	localparam int VCOUNT_W = 5;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

	// Default size of the distance matrix.
	localparam int MAX_VERTICES_DEFAULT = 16;

	// Register port layout.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Command codes carried by an input item.
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_COMPUTE = 2'd1,
		CMD_READ    = 2'd2
	} cmd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FETCH,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

endpackage

### sv/all_pairs_shortest_path_top.sv
// All-pairs shortest path engine. The distance matrix lives in one RAM with a
// write port and two registered read ports, addressed as row and column. An item
// is taken when start is high and busy is low. A load is written as it is taken
// and gives no result. A read goes through ST_READ and the result register. A
// compute item runs the relaxation in k, i, j order over n = min(vertex_count,
// MAX_VERTICES) vertices: each (k, i) pass fetches the i,k entry in ST_FETCH and
// then streams one j per cycle through the RAM, bounded by the single RAM write
// port; after the last pass ST_DRAIN and the result register give the done
// result. With a vertex count of zero the done result follows in the cycle after
// the item. Every result is shown for exactly one cycle with result_strobe high
// and must be taken then; the block cannot be stalled from the result side.
module all_pairs_shortest_path_top #(
	parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Command channel.
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          cmd,
	input  logic [3:0]                          row,
	input  logic [3:0]                          col,
	input  logic [apsp_pkg::DIST_W-1:0]         edge_weight,
	// Result channel.
	output logic                                result_strobe,
	output logic [apsp_pkg::DIST_W-1:0]         distance,
	output logic                                unreachable,
	output logic                                closure_done,
	// Register port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [apsp_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [apsp_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [apsp_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int IdxW  = $clog2(MAX_VERTICES);
	localparam int AddrW = 2 * IdxW;
	localparam int NW    = $clog2(MAX_VERTICES + 1);
	localparam int DW    = apsp_pkg::DIST_W;

	apsp_pkg::state_t state_q, state_d;

	logic [apsp_pkg::VCOUNT_W-1:0] vcount_q;
	logic [IdxW-1:0]               k_q, i_q, j_q;
	logic [DW-1:0]                 ik_q;
	logic                          valid_s1;
	logic [AddrW-1:0]              waddr_s1;
	logic                          inside_q;
	logic                          strobe_q;
	logic [DW-1:0]                 distance_q;
	logic                          unreachable_q;
	logic                          closure_done_q;

	logic                          accept;
	logic                          in_bounds;
	logic [NW-1:0]                 n_lim;
	logic [NW-1:0]                 n_last;
	logic                          j_last, i_last, k_last;
	logic                          set_result;
	logic [DW-1:0]                 sat_weight;
	logic [DW:0]                   sum;
	logic                          relax;
	logic                          load_we;
	logic                          mem_we;
	logic [AddrW-1:0]              mem_waddr;
	logic [DW-1:0]                 mem_wdata;
	logic [AddrW-1:0]              raddr_a, raddr_b;
	logic [DW-1:0]                 rdata_a, rdata_b;
	logic [DW-1:0]                 read_dist;
	logic                          cfg_write;

	// Register port: always ready, one register at index zero.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
		(paddr[2] == apsp_pkg::REG_VERTEX_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= apsp_pkg::VCOUNT_RESET;
		end else if (cfg_write) begin
			vcount_q <= pwdata[apsp_pkg::VCOUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == apsp_pkg::REG_VERTEX_COUNT) begin
			prdata[apsp_pkg::VCOUNT_W-1:0] = vcount_q;
		end
	end

	// Command handshake and item decode.
	assign busy       = (state_q != apsp_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign in_bounds  = (int'(row) < MAX_VERTICES) && (int'(col) < MAX_VERTICES);
	assign sat_weight = (edge_weight > apsp_pkg::NO_EDGE) ? apsp_pkg::NO_EDGE : edge_weight;

	// Vertices taking part in the closure, and loop end detection.
	assign n_lim  = (int'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);
	assign n_last = n_lim - NW'(1);
	assign j_last = (NW'(j_q) == n_last);
	assign i_last = (NW'(i_q) == n_last);
	assign k_last = (NW'(k_q) == n_last);

	// Next state and result launch.
	always_comb begin
		state_d    = state_q;
		set_result = 1'b0;
		unique case (state_q)
			apsp_pkg::ST_IDLE: begin
				if (accept) begin
					priority case (cmd)
						apsp_pkg::CMD_COMPUTE: begin
							if (n_lim == '0) begin
								set_result = 1'b1;
							end else begin
								state_d = apsp_pkg::ST_FETCH;
							end
						end
						apsp_pkg::CMD_READ: state_d = apsp_pkg::ST_READ;
						default:            state_d = apsp_pkg::ST_IDLE;
					endcase
				end
			end
			apsp_pkg::ST_READ: begin
				set_result = 1'b1;
				state_d    = apsp_pkg::ST_IDLE;
			end
			apsp_pkg::ST_FETCH: begin
				state_d = apsp_pkg::ST_SWEEP;
			end
			apsp_pkg::ST_SWEEP: begin
				if (j_last) begin
					state_d = (i_last && k_last) ? apsp_pkg::ST_DRAIN : apsp_pkg::ST_FETCH;
				end
			end
			apsp_pkg::ST_DRAIN: begin
				set_result = 1'b1;
				state_d    = apsp_pkg::ST_IDLE;
			end
			default: state_d = apsp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Loop counters: j streams within a row, i and k advance at row ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else if (accept) begin
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else if (state_q == apsp_pkg::ST_SWEEP) begin
			if (j_last) begin
				j_q <= '0;
				if (i_last) begin
					i_q <= '0;
					k_q <= k_q + IdxW'(1);
				end else begin
					i_q <= i_q + IdxW'(1);
				end
			end else begin
				j_q <= j_q + IdxW'(1);
			end
		end
	end

	// Read addresses: port A fetches the i,k entry, then row k; port B reads row i
	// during a sweep and the requested entry for a read item.
	always_comb begin
		if (state_q == apsp_pkg::ST_FETCH) begin
			raddr_a = {i_q, k_q};
		end else begin
			raddr_a = {k_q, j_q};
		end
		if (state_q == apsp_pkg::ST_IDLE) begin
			raddr_b = {IdxW'(row), IdxW'(col)};
		end else begin
			raddr_b = {i_q, j_q};
		end
	end

	// Relaxation stage, in the cycle after the sweep reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == apsp_pkg::ST_SWEEP);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= {i_q, j_q};
		// The first sweep cycle sees the i,k entry fetched the cycle before.
		if ((state_q == apsp_pkg::ST_SWEEP) && (j_q == '0)) begin
			ik_q <= rdata_a;
		end
	end

	assign sum   = {1'b0, ik_q} + {1'b0, rdata_a};
	assign relax = valid_s1 && (ik_q != apsp_pkg::NO_EDGE) &&
		(rdata_a != apsp_pkg::NO_EDGE) && (sum < {1'b0, rdata_b});

	// Write port: loads happen only while idle, relaxations only while busy.
	assign load_we   = accept && (cmd == apsp_pkg::CMD_LOAD) && in_bounds;
	assign mem_we    = load_we || relax;
	assign mem_waddr = load_we ? {IdxW'(row), IdxW'(col)} : waddr_s1;
	assign mem_wdata = load_we ? sat_weight : sum[DW-1:0];

	apsp_mem #(
		.AddrW(AddrW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			inside_q <= in_bounds;
		end
	end

	assign read_dist = inside_q ? rdata_b : apsp_pkg::NO_EDGE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= set_result;
		end
	end

	always_ff @(posedge clk) begin
		if (set_result) begin
			if (state_q == apsp_pkg::ST_READ) begin
				distance_q     <= read_dist;
				unreachable_q  <= (read_dist == apsp_pkg::NO_EDGE);
				closure_done_q <= 1'b0;
			end else begin
				distance_q     <= '0;
				unreachable_q  <= 1'b0;
				closure_done_q <= 1'b1;
			end
		end
	end

	assign result_strobe = strobe_q;
	assign distance      = distance_q;
	assign unreachable   = unreachable_q;
	assign closure_done  = closure_done_q;

endmodule

### sv/apsp_mem.sv
module apsp_mem #(
	parameter int AddrW = 8
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AddrW-1:0]                 waddr,
	input  logic [apsp_pkg::DIST_W-1:0]      wdata,
	input  logic [AddrW-1:0]                 raddr_a,
	input  logic [AddrW-1:0]                 raddr_b,
	output logic [apsp_pkg::DIST_W-1:0]      rdata_a,
	output logic [apsp_pkg::DIST_W-1:0]      rdata_b
);

	localparam int Depth = 1 << AddrW;

	logic [apsp_pkg::DIST_W-1:0] mem [Depth];

	// One write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Two read ports with registered data.
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### verif/all_pairs_shortest_path_top_tb.sv
module all_pairs_shortest_path_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXV = apsp_pkg::MAX_VERTICES_DEFAULT;
	localparam int DIST_W = apsp_pkg::DIST_W;
	localparam int VCOUNT_W = apsp_pkg::VCOUNT_W;
	localparam int APB_ADDR_W = apsp_pkg::APB_ADDR_W;
	localparam int APB_DATA_W = apsp_pkg::APB_DATA_W;
	localparam logic [DIST_W-1:0] NO_EDGE = apsp_pkg::NO_EDGE;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 23;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [APB_ADDR_W-1:0] VCOUNT_ADDR =
		APB_ADDR_W'(apsp_pkg::REG_VERTEX_COUNT) << 2;

	// One command item as handed to the block.
	typedef struct {
		logic [1:0]        op;
		logic [3:0]        row;
		logic [3:0]        col;
		logic [DIST_W-1:0] weight;
	} command_t;

	// One result item as the block should show it.
	typedef struct {
		logic [DIST_W-1:0] dist_val;
		logic              unreach;
		logic              done;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cmd = apsp_pkg::CMD_LOAD;
	logic [3:0] row = '0;
	logic [3:0] col = '0;
	logic [DIST_W-1:0] edge_weight = '0;
	logic result_strobe;
	logic [DIST_W-1:0] distance;
	logic unreachable;
	logic closure_done;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// Predicted matrix contents and register value.
	logic [DIST_W-1:0] dist_table [MAXV][MAXV];
	logic [VCOUNT_W-1:0] vcount_shadow = apsp_pkg::VCOUNT_RESET;

	command_t command_q [$];
	answer_t owed_answers [$];
	command_t in_flight;
	logic calm_stretch = 1'b0;

	int mismatch_count = 0;
	int cycle_count = 0;
	int load_count = 0;
	int closure_count = 0;
	int read_count = 0;
	int ignored_count = 0;
	int checked_count = 0;

	all_pairs_shortest_path_top #(
		.MAX_VERTICES(MAXV)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.row(row),
		.col(col),
		.edge_weight(edge_weight),
		.result_strobe(result_strobe),
		.distance(distance),
		.unreachable(unreachable),
		.closure_done(closure_done),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// Floyd-Warshall relaxation over the first n vertices, k outermost.
	function automatic void relax_matrix();
		int unsigned n;
		int unsigned via_k;
		int unsigned from_k;
		int unsigned here;
		n = (vcount_shadow > MAXV) ? MAXV : vcount_shadow;
		for (int unsigned k = 0; k < n; k++) begin
			for (int unsigned i = 0; i < n; i++) begin
				if (dist_table[i][k] == NO_EDGE)
					continue;
				for (int unsigned j = 0; j < n; j++) begin
					from_k = dist_table[k][j];
					here = dist_table[i][j];
					via_k = dist_table[i][k];
					if (via_k != NO_EDGE && from_k != NO_EDGE && via_k + from_k < here)
						dist_table[i][j] = DIST_W'(via_k + from_k);
				end
			end
		end
	endfunction

	// Update the predicted matrix for an accepted item and queue the answer it owes, if any.
	function automatic void apply_command(input command_t c);
		logic [DIST_W-1:0] w;
		logic [DIST_W-1:0] d;
		logic in_range;
		w = (c.weight > NO_EDGE) ? NO_EDGE : c.weight;
		in_range = (c.row < MAXV) && (c.col < MAXV);
		case (c.op)
			apsp_pkg::CMD_LOAD: begin
				if (in_range)
					dist_table[c.row][c.col] = w;
				load_count++;
			end
			apsp_pkg::CMD_COMPUTE: begin
				relax_matrix();
				owed_answers.push_back('{dist_val: '0, unreach: 1'b0, done: 1'b1});
				closure_count++;
			end
			apsp_pkg::CMD_READ: begin
				d = in_range ? dist_table[c.row][c.col] : NO_EDGE;
				owed_answers.push_back('{dist_val: d, unreach: (d == NO_EDGE), done: 1'b0});
				read_count++;
			end
			default: begin
				ignored_count++;
			end
		endcase
	endfunction

	// Weights lean toward short edges and missing edges, with the extremes mixed in.
	function automatic logic [DIST_W-1:0] random_weight();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return NO_EDGE;
		else if (roll < 45)
			return '0;
		else if (roll < 50)
			return DIST_W'($urandom_range(16383, 10000));
		else if (roll < 53)
			return DIST_W'(9998);
		else
			return DIST_W'($urandom_range(60, 1));
	endfunction

	// Indexes mostly fall inside the active vertex range.
	function automatic logic [3:0] random_index(input int unsigned n);
		int unsigned top;
		top = (n > MAXV) ? MAXV : n;
		if (top == 0 || $urandom_range(99) < 30)
			return 4'($urandom_range(15));
		return 4'($urandom_range(top - 1));
	endfunction

	function automatic command_t random_command(input int unsigned n);
		command_t c;
		int unsigned roll;
		roll = $urandom_range(99);
		c.row = random_index(n);
		c.col = random_index(n);
		c.weight = DIST_W'($urandom_range(16383));
		if (roll < 45) begin
			c.op = apsp_pkg::CMD_LOAD;
			c.weight = random_weight();
		end else if (roll < 87) begin
			c.op = apsp_pkg::CMD_READ;
		end else if (roll < 94) begin
			c.op = apsp_pkg::CMD_COMPUTE;
		end else begin
			c.op = CMD_UNUSED;
		end
		return c;
	endfunction

	function automatic command_t make_command(input logic [1:0] op, input int unsigned r,
			input int unsigned c, input int unsigned w);
		command_t item;
		item.op = op;
		item.row = 4'(r);
		item.col = 4'(c);
		item.weight = DIST_W'(w);
		return item;
	endfunction

	// Write the vertex count over the register port, then read it back.
	task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= VCOUNT_ADDR;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		vcount_shadow = value;
		check_vertex_count();
	endtask

	task automatic check_vertex_count();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= VCOUNT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		if (prdata !== APB_DATA_W'(vcount_shadow))
			flag_mismatch($sformatf("vertex count reads %0d, want %0d", prdata, vcount_shadow));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Hold the sender back until the block has answered everything and settled.
	task automatic wait_for_quiet();
		@(negedge clk);
		while (command_q.size() != 0 || start || owed_answers.size() != 0 || busy)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Driver: present queued items, idling now and then.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				apply_command(in_flight);
			if (!start || !busy) begin
				if (command_q.size() != 0 && (calm_stretch || $urandom_range(99) >= 14)) begin
					in_flight = command_q.pop_front();
					start <= 1'b1;
					cmd <= in_flight.op;
					row <= in_flight.row;
					col <= in_flight.col;
					edge_weight <= in_flight.weight;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result is checked against the oldest owed answer.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && result_strobe) begin
			if (owed_answers.size() == 0) begin
				flag_mismatch($sformatf("unexpected result distance %0d done %0b",
					distance, closure_done));
			end else begin
				want = owed_answers.pop_front();
				checked_count++;
				if (distance !== want.dist_val)
					flag_mismatch($sformatf("distance %0d, want %0d", distance,
						want.dist_val));
				if (unreachable !== want.unreach)
					flag_mismatch($sformatf("unreachable %0b, want %0b", unreachable,
						want.unreach));
				if (closure_done !== want.done)
					flag_mismatch($sformatf("closure_done %0b, want %0b", closure_done,
						want.done));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [VCOUNT_W-1:0] vcount_plan [6];
		command_t item;
		vcount_plan = '{5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd2};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_vertex_count();

		// Every entry is written before any closure or read, diagonal mostly zero.
		for (int r = 0; r < MAXV; r++) begin
			for (int c = 0; c < MAXV; c++) begin
				item = make_command(apsp_pkg::CMD_LOAD, r, c, 0);
				if (r != c || $urandom_range(99) < 10)
					item.weight = random_weight();
				command_q.push_back(item);
			end
		end
		wait_for_quiet();

		// Directed items: corner indexes, weight extremes, saturation, unused code.
		command_q.push_back(make_command(apsp_pkg::CMD_LOAD, 0, 0, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_LOAD, 15, 15, 16383));
		command_q.push_back(make_command(apsp_pkg::CMD_LOAD, 0, 15, 9998));
		command_q.push_back(make_command(apsp_pkg::CMD_LOAD, 15, 0, 10000));
		command_q.push_back(make_command(apsp_pkg::CMD_LOAD, 3, 4, 1));
		command_q.push_back(make_command(apsp_pkg::CMD_LOAD, 4, 3, 9999));
		command_q.push_back(make_command(CMD_UNUSED, 15, 15, 16383));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 0, 0, 16383));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 15, 15, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 0, 15, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 15, 0, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 3, 4, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_COMPUTE, 0, 0, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 0, 15, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 15, 0, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 3, 3, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 15, 15, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_LOAD, 15, 15, 0));
		command_q.push_back(make_command(apsp_pkg::CMD_READ, 15, 15, 0));
		command_q.push_back(make_command(CMD_UNUSED, 0, 0, 0));
		wait_for_quiet();

		// Random phases, each under its own vertex count; one phase never idles.
		for (int p = 0; p < 6; p++) begin
			write_vertex_count(vcount_plan[p]);
			calm_stretch = (p == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					command_q.push_back(make_command(apsp_pkg::CMD_COMPUTE, 0, 0, 0));
				else
					command_q.push_back(random_command(vcount_plan[p]));
			end
			wait_for_quiet();
		end
		calm_stretch = 1'b0;
		repeat (20) @(negedge clk);

		$display("Covered %0d loads, %0d closures, %0d reads and %0d unused codes;",
			load_count, closure_count, read_count, ignored_count);
		$display("checked %0d results over vertex counts 16, 1, 0, 31, 5, 16 and 2.",
			checked_count);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
